// ===== hw/rtl/fpba_pkg.sv =====
// fpba_pkg: shared types and codes for the fit-policy block allocator.
// Used by fpba_cell and fit_policy_block_allocator_unit; no dependencies.

package fpba_pkg;

	typedef enum logic [1:0] {
		POL_FIRST = 2'd0,
		POL_BEST  = 2'd1,
		POL_WORST = 2'd2,
		POL_NEXT  = 2'd3
	} policy_t;

	// configuration register indexes
	localparam logic REG_POLICY      = 1'b0;
	localparam logic REG_BLOCK_COUNT = 1'b1;

	// item kinds
	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	// request broadcast to every cell while a scan runs
	typedef struct packed {
		logic [15:0] req;
		policy_t     policy;
		logic [4:0]  cnt;
		logic [4:0]  start_ptr;
	} scan_cmd_t;

	// candidate flags carried along the chain
	typedef struct packed {
		logic main_valid;
		logic lo_valid;
	} tok_ctl_t;

endpackage

// ===== hw/rtl/fit_policy_block_allocator_unit.sv =====
// fit_policy_block_allocator_unit: top level of the block allocator.
// Depends on fpba_pkg and fpba_cell.

// A load (kind 0) gives no result; busy stays low.
// A request (kind 1) travels down a chain of NUM_BLOCKS cells, one cell per
// cycle, and its result appears with done high for one cycle; busy stays high
// until then, so a new item is not taken while a request scans. A new item can
// start in the done cycle.
// Results cannot be held off; take them on the done cycle.

module fit_policy_block_allocator_unit #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [3:0]  slot,
	input  logic [15:0] load_size,
	input  logic [15:0] request_size,
	output logic        done,
	output logic        granted,
	output logic [3:0]  granted_slot,
	output logic [15:0] remainder
);

	localparam int IDX_W = $clog2(NUM_BLOCKS);
	localparam int CW    = $clog2(NUM_BLOCKS + 1);
	localparam int PW    = (IDX_W > 5) ? IDX_W : 5;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       cnt_q;
	fpba_pkg::scan_cmd_t cmd_q;
	fpba_pkg::policy_t   policy_q;
	logic [4:0]          bcount_q;
	logic [IDX_W-1:0]    ptr_q;
	logic                done_q;
	logic                granted_q;
	logic [3:0]          slot_q;
	logic [15:0]         rem_q;

	fpba_pkg::tok_ctl_t   tok_ctl  [NUM_BLOCKS+1];
	logic [IDX_W-1:0]     main_idx [NUM_BLOCKS+1];
	logic [SIZE_BITS-1:0] main_cap [NUM_BLOCKS+1];
	logic [IDX_W-1:0]     lo_idx   [NUM_BLOCKS+1];
	logic [SIZE_BITS-1:0] lo_cap   [NUM_BLOCKS+1];

	logic                 accept;
	logic                 load_ok;
	logic                 finish;
	logic [4:0]           act_cnt;
	logic [4:0]           start_ptr;
	logic                 sel_valid;
	logic [IDX_W-1:0]     sel_idx;
	logic [SIZE_BITS-1:0] sel_cap;
	logic [SIZE_BITS-1:0] sel_rem;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_idx;
	logic [SIZE_BITS-1:0] wr_data;

	assign busy    = (state_q == S_SCAN);
	assign accept  = start && !busy;
	assign load_ok = 9'(slot) < 9'(NUM_BLOCKS);
	assign finish  = (state_q == S_SCAN) && (cnt_q == '0);

	always_comb begin
		act_cnt = (9'(bcount_q) > 9'(NUM_BLOCKS)) ? 5'(NUM_BLOCKS) : bcount_q;
		start_ptr = (PW'(ptr_q) < PW'(act_cnt)) ? 5'(ptr_q) : 5'd0;
	end

	assign tok_ctl[0]  = '0;
	assign main_idx[0] = '0;
	assign main_cap[0] = '0;
	assign lo_idx[0]   = '0;
	assign lo_cap[0]   = '0;

	for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
		fpba_cell #(
			.IDX_W      (IDX_W),
			.SIZE_BITS  (SIZE_BITS),
			.CELL_INDEX (g)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd_q),
			.wr_en        (wr_en),
			.wr_idx       (wr_idx),
			.wr_data      (wr_data),
			.in_ctl       (tok_ctl[g]),
			.in_main_idx  (main_idx[g]),
			.in_main_cap  (main_cap[g]),
			.in_lo_idx    (lo_idx[g]),
			.in_lo_cap    (lo_cap[g]),
			.out_ctl      (tok_ctl[g+1]),
			.out_main_idx (main_idx[g+1]),
			.out_main_cap (main_cap[g+1]),
			.out_lo_idx   (lo_idx[g+1]),
			.out_lo_cap   (lo_cap[g+1])
		);
	end

	// wrapped part of a next-fit scan only counts when nothing fit at or past the pointer
	always_comb begin
		sel_valid = tok_ctl[NUM_BLOCKS].main_valid || tok_ctl[NUM_BLOCKS].lo_valid;
		sel_idx   = tok_ctl[NUM_BLOCKS].main_valid ? main_idx[NUM_BLOCKS] : lo_idx[NUM_BLOCKS];
		sel_cap   = tok_ctl[NUM_BLOCKS].main_valid ? main_cap[NUM_BLOCKS] : lo_cap[NUM_BLOCKS];
		sel_rem   = sel_cap - SIZE_BITS'(cmd_q.req);
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = sel_idx;
		wr_data = sel_rem;
		if (finish) begin
			wr_en = sel_valid;
		end else if (accept && (kind == fpba_pkg::KIND_LOAD)) begin
			wr_en   = load_ok;
			wr_idx  = IDX_W'(slot);
			wr_data = SIZE_BITS'(load_size);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			cmd_q     <= '0;
			policy_q  <= fpba_pkg::POL_FIRST;
			bcount_q  <= 5'd16;
			ptr_q     <= '0;
			done_q    <= 1'b0;
			granted_q <= 1'b0;
			slot_q    <= '0;
			rem_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					fpba_pkg::REG_POLICY: begin
						policy_q <= fpba_pkg::policy_t'(cfg_data[1:0]);
					end
					fpba_pkg::REG_BLOCK_COUNT: begin
						bcount_q <= cfg_data;
					end
					default: begin
						policy_q <= policy_q;
					end
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (kind == fpba_pkg::KIND_LOAD) begin
							if (load_ok) begin
								ptr_q <= '0;
							end
						end else begin
							cmd_q.req       <= request_size;
							cmd_q.policy    <= policy_q;
							cmd_q.cnt       <= act_cnt;
							cmd_q.start_ptr <= start_ptr;
							cnt_q           <= CW'(NUM_BLOCKS);
							state_q         <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (cnt_q == '0) begin
						done_q    <= 1'b1;
						granted_q <= sel_valid;
						slot_q    <= sel_valid ? 4'(sel_idx) : 4'd0;
						rem_q     <= sel_valid ? 16'(sel_rem) : 16'd0;
						if (sel_valid && (cmd_q.policy == fpba_pkg::POL_NEXT)) begin
							ptr_q <= sel_idx;
						end
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign granted      = granted_q;
	assign granted_slot = slot_q;
	assign remainder    = rem_q;

`ifndef SYNTHESIS
	a_req_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (kind == fpba_pkg::KIND_REQUEST)) |=> busy)
		else $error("request did not start a scan");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result issued while still scanning");

	a_grant_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && granted) |-> ({1'b0, granted_slot} < cmd_q.cnt))
		else $error("granted block outside the active range");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (kind == fpba_pkg::KIND_LOAD)) |=> (!done && !busy))
		else $error("load produced a result or a scan");
`endif

endmodule

// ===== hw/rtl/fpba_cell.sv =====
// fpba_cell: one block of the allocator chain; holds one capacity and
// refines the running candidate passed from its left neighbor.
// Depends on fpba_pkg.

module fpba_cell #(
	parameter int IDX_W      = 4,
	parameter int SIZE_BITS  = 16,
	parameter int CELL_INDEX = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  fpba_pkg::scan_cmd_t      cmd,
	input  logic                     wr_en,
	input  logic [IDX_W-1:0]         wr_idx,
	input  logic [SIZE_BITS-1:0]     wr_data,
	input  fpba_pkg::tok_ctl_t       in_ctl,
	input  logic [IDX_W-1:0]         in_main_idx,
	input  logic [SIZE_BITS-1:0]     in_main_cap,
	input  logic [IDX_W-1:0]         in_lo_idx,
	input  logic [SIZE_BITS-1:0]     in_lo_cap,
	output fpba_pkg::tok_ctl_t       out_ctl,
	output logic [IDX_W-1:0]         out_main_idx,
	output logic [SIZE_BITS-1:0]     out_main_cap,
	output logic [IDX_W-1:0]         out_lo_idx,
	output logic [SIZE_BITS-1:0]     out_lo_cap
);

	localparam int CMP_W = (SIZE_BITS > 16) ? SIZE_BITS : 16;
	localparam logic [8:0] POS = 9'(CELL_INDEX);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

	logic [SIZE_BITS-1:0] cap_q;
	logic                 fits;
	logic                 hi_side;
	logic                 take_main;
	logic                 take_lo;
	fpba_pkg::tok_ctl_t   ctl_q;
	logic [IDX_W-1:0]     main_idx_q;
	logic [SIZE_BITS-1:0] main_cap_q;
	logic [IDX_W-1:0]     lo_idx_q;
	logic [SIZE_BITS-1:0] lo_cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
		end else if (wr_en && (wr_idx == MY_IDX)) begin
			cap_q <= wr_data;
		end
	end

	always_comb begin
		fits    = (POS < 9'(cmd.cnt)) && (CMP_W'(cap_q) >= CMP_W'(cmd.req));
		hi_side = (POS >= 9'(cmd.start_ptr));
		take_main = 1'b0;
		take_lo   = 1'b0;
		case (cmd.policy)
			fpba_pkg::POL_FIRST: begin
				take_main = fits && !in_ctl.main_valid;
			end
			fpba_pkg::POL_BEST: begin
				take_main = fits && (!in_ctl.main_valid || (cap_q < in_main_cap));
			end
			fpba_pkg::POL_WORST: begin
				take_main = fits && (!in_ctl.main_valid || (cap_q > in_main_cap));
			end
			fpba_pkg::POL_NEXT: begin
				take_main = fits && hi_side && !in_ctl.main_valid;
				take_lo   = fits && !hi_side && !in_ctl.lo_valid;
			end
			default: begin
				take_main = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		ctl_q.main_valid <= in_ctl.main_valid || take_main;
		ctl_q.lo_valid   <= in_ctl.lo_valid || take_lo;
		main_idx_q       <= take_main ? MY_IDX : in_main_idx;
		main_cap_q       <= take_main ? cap_q : in_main_cap;
		lo_idx_q         <= take_lo ? MY_IDX : in_lo_idx;
		lo_cap_q         <= take_lo ? cap_q : in_lo_cap;
	end

	assign out_ctl      = ctl_q;
	assign out_main_idx = main_idx_q;
	assign out_main_cap = main_cap_q;
	assign out_lo_idx   = lo_idx_q;
	assign out_lo_cap   = lo_cap_q;

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench for fit_policy_block_allocator_unit.
// Runs a directed table and then random load/request traffic,
// checked against an internal allocator model. Depends on fpba_pkg and the allocator RTL.

module tb_top;

	localparam int NBLK       = 16;
	localparam int DRAIN      = NBLK + 4;
	localparam int WATCHDOG   = 500;
	localparam int RAND_ITEMS = 750;
	localparam int PHASES     = 8;

	typedef struct {
		bit          granted;
		bit [3:0]    slot;
		bit [15:0]   rem;
	} grant_t;

	typedef struct {
		bit          is_cfg;
		bit          cfg_idx;
		bit [4:0]    cfg_val;
		bit          k;
		bit [3:0]    s;
		bit [15:0]   ld;
		bit [15:0]   rq;
		bit          typed;
		grant_t      exp;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [4:0]  cfg_data = '0;
	logic        start = 1'b0;
	logic        busy;
	logic        kind = 1'b0;
	logic [3:0]  slot = '0;
	logic [15:0] load_size = '0;
	logic [15:0] request_size = '0;
	logic        done;
	logic        granted;
	logic [3:0]  granted_slot;
	logic [15:0] remainder;

	// allocator state mirror
	bit [15:0]         free_cap [NBLK];
	int                scan_ptr;
	fpba_pkg::policy_t cur_policy;
	bit [4:0]          cur_count;

	grant_t      grant_q [$];
	grant_t      head;
	row_t        directed_rows [$];
	int          errors;
	int          idle_cycles;
	int          n_loads;
	int          n_reqs;
	int          n_grants;
	bit          gaps_on;

	fit_policy_block_allocator_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.slot         (slot),
		.load_size    (load_size),
		.request_size (request_size),
		.done         (done),
		.granted      (granted),
		.granted_slot (granted_slot),
		.remainder    (remainder)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic grant_t compute_grant(bit [15:0] rq);
		int cnt;
		int pos;
		int pick;
		grant_t g;
		cnt = (cur_count > NBLK) ? NBLK : int'(cur_count);
		pick = -1;
		g = '{1'b0, 4'd0, 16'd0};
		if (cnt != 0) begin
			if (cur_policy == fpba_pkg::POL_NEXT) begin
				pos = (scan_ptr < cnt) ? scan_ptr : 0;
				for (int i = 0; i < cnt; i++) begin
					if (free_cap[pos] >= rq) begin
						pick = pos;
						break;
					end
					pos = (pos + 1 == cnt) ? 0 : pos + 1;
				end
			end else begin
				for (int i = 0; i < cnt; i++) begin
					if (free_cap[i] >= rq) begin
						if (pick < 0)
							pick = i;
						else if (cur_policy == fpba_pkg::POL_BEST
							&& free_cap[i] < free_cap[pick])
							pick = i;
						else if (cur_policy == fpba_pkg::POL_WORST
							&& free_cap[i] > free_cap[pick])
							pick = i;
						if (cur_policy == fpba_pkg::POL_FIRST)
							break;
					end
				end
			end
		end
		if (pick >= 0) begin
			free_cap[pick] = free_cap[pick] - rq;
			if (cur_policy == fpba_pkg::POL_NEXT)
				scan_ptr = pick;
			g = '{1'b1, 4'(pick), free_cap[pick]};
		end
		return g;
	endfunction

	function automatic row_t cfg_row(bit idx, bit [4:0] val);
		row_t r;
		r = '{default: '0, exp: '{1'b0, 4'd0, 16'd0}};
		r.is_cfg = 1'b1;
		r.cfg_idx = idx;
		r.cfg_val = val;
		return r;
	endfunction

	function automatic row_t load_row(bit [3:0] s, bit [15:0] ld);
		row_t r;
		r = '{default: '0, exp: '{1'b0, 4'd0, 16'd0}};
		r.k = fpba_pkg::KIND_LOAD;
		r.s = s;
		r.ld = ld;
		return r;
	endfunction

	function automatic row_t req_row(bit [15:0] rq);
		row_t r;
		r = '{default: '0, exp: '{1'b0, 4'd0, 16'd0}};
		r.k = fpba_pkg::KIND_REQUEST;
		r.rq = rq;
		r.s = 4'($urandom_range(0, 15));
		r.ld = 16'($urandom_range(0, 65535));
		return r;
	endfunction

	function automatic row_t req_typed(bit [15:0] rq, bit g, bit [3:0] gs, bit [15:0] rem);
		row_t r;
		r = req_row(rq);
		r.typed = 1'b1;
		r.exp = '{g, gs, rem};
		return r;
	endfunction

	// register writes only once the block is idle
	task automatic set_config(bit idx, bit [4:0] val);
		start <= 1'b0;
		while (grant_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == fpba_pkg::REG_POLICY)
			cur_policy = fpba_pkg::policy_t'(val[1:0]);
		else
			cur_count = val;
	endtask

	task automatic send_item(row_t r);
		grant_t g;
		kind <= r.k;
		slot <= r.s;
		load_size <= r.ld;
		request_size <= r.rq;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		if (r.k == fpba_pkg::KIND_LOAD) begin
			free_cap[r.s] = r.ld;
			scan_ptr = 0;
			n_loads++;
		end else begin
			g = compute_grant(r.rq);
			grant_q.push_back(r.typed ? r.exp : g);
			n_reqs++;
			if (g.granted)
				n_grants++;
		end
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (grant_q.size() == 0) begin
				$error("result with no request pending");
				errors++;
			end else begin
				head = grant_q.pop_front();
				if (granted !== head.granted) begin
					$error("granted: expected %0d, got %0d", head.granted, granted);
					errors++;
				end
				if (granted_slot !== head.slot) begin
					$error("granted_slot: expected %0d, got %0d", head.slot, granted_slot);
					errors++;
				end
				if (remainder !== head.rem) begin
					$error("remainder: expected %0d, got %0d", head.rem, remainder);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done === 1'b1 || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		row_t r;
		int per_phase;
		int pick_slot;
		bit [4:0] cnt_val;
		for (int i = 0; i < NBLK; i++)
			free_cap[i] = '0;
		scan_ptr = 0;
		cur_policy = fpba_pkg::POL_FIRST;
		cur_count = 5'd16;
		gaps_on = 1'b1;

		directed_rows.push_back(req_typed(16'd0, 1'b1, 4'd0, 16'd0));
		directed_rows.push_back(req_typed(16'd1, 1'b0, 4'd0, 16'd0));
		directed_rows.push_back(load_row(4'd15, 16'hFFFF));
		directed_rows.push_back(load_row(4'd3, 16'd100));
		directed_rows.push_back(load_row(4'd5, 16'd50));
		directed_rows.push_back(load_row(4'd8, 16'd200));
		directed_rows.push_back(req_typed(16'hFFFF, 1'b1, 4'd15, 16'd0));
		directed_rows.push_back(req_row(16'd60));
		directed_rows.push_back(cfg_row(fpba_pkg::REG_POLICY, 5'(fpba_pkg::POL_BEST)));
		directed_rows.push_back(req_row(16'd45));
		directed_rows.push_back(req_row(16'd5));
		directed_rows.push_back(cfg_row(fpba_pkg::REG_POLICY, 5'(fpba_pkg::POL_WORST)));
		directed_rows.push_back(req_row(16'd10));
		directed_rows.push_back(load_row(4'd1, 16'd190));
		directed_rows.push_back(req_row(16'd0));
		directed_rows.push_back(cfg_row(fpba_pkg::REG_POLICY, 5'(fpba_pkg::POL_NEXT)));
		directed_rows.push_back(req_row(16'd30));
		directed_rows.push_back(req_row(16'd170));
		directed_rows.push_back(cfg_row(fpba_pkg::REG_BLOCK_COUNT, 5'd4));
		directed_rows.push_back(req_row(16'd30));
		directed_rows.push_back(load_row(4'd12, 16'hAAAA));
		directed_rows.push_back(load_row(4'd13, 16'h5555));
		directed_rows.push_back(req_typed(16'hFFFF, 1'b0, 4'd0, 16'd0));
		directed_rows.push_back(cfg_row(fpba_pkg::REG_BLOCK_COUNT, 5'd0));
		directed_rows.push_back(req_typed(16'd0, 1'b0, 4'd0, 16'd0));
		directed_rows.push_back(cfg_row(fpba_pkg::REG_BLOCK_COUNT, 5'd31));
		directed_rows.push_back(req_row(16'h5555));
		directed_rows.push_back(req_row(16'hAAAA));
		directed_rows.push_back(cfg_row(fpba_pkg::REG_BLOCK_COUNT, 5'd1));
		directed_rows.push_back(req_row(16'd0));
		directed_rows.push_back(load_row(4'd0, 16'd7));
		directed_rows.push_back(req_row(16'd7));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg)
				set_config(directed_rows[i].cfg_idx, directed_rows[i].cfg_val);
			else
				send_item(directed_rows[i]);
		end

		per_phase = RAND_ITEMS / PHASES;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: cnt_val = 5'd16;
				1: cnt_val = 5'd1;
				2: cnt_val = 5'd31;
				3: cnt_val = 5'd2;
				4: cnt_val = 5'd0;
				5: cnt_val = 5'($urandom_range(3, 15));
				default: cnt_val = 5'($urandom_range(8, 31));
			endcase
			set_config(fpba_pkg::REG_POLICY, 5'(fpba_pkg::policy_t'(ph % 4)));
			set_config(fpba_pkg::REG_BLOCK_COUNT, cnt_val);
			gaps_on = (ph < PHASES - 2) && (ph != 2);
			for (int i = 0; i < per_phase; i++) begin
				if (ph == 1 && i == per_phase / 2) begin
					start <= 1'b0;
					do
						@(posedge clk);
					while (grant_q.size() != 0);
				end
				pick_slot = $urandom_range(0, 15);
				if ($urandom_range(0, 9) < 3) begin
					r = load_row(4'(pick_slot), 16'd0);
					case ($urandom_range(0, 3))
						0: r.ld = 16'($urandom_range(0, 65535));
						1: r.ld = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
						default: r.ld = 16'($urandom_range(0, 2000));
					endcase
				end else begin
					r = req_row(16'd0);
					case ($urandom_range(0, 4))
						0: r.rq = 16'($urandom_range(0, 65535));
						1: r.rq = free_cap[pick_slot];
						2: r.rq = 16'($urandom_range(0, free_cap[pick_slot]));
						3: r.rq = 16'($urandom_range(0, 64));
						default: r.rq = free_cap[pick_slot] + 16'd1;
					endcase
				end
				send_item(r);
			end
		end

		start <= 1'b0;
		while (grant_q.size() != 0)
			@(posedge clk);
		repeat (2 * DRAIN) @(posedge clk);

		$display("Covered %0d loads and %0d requests (%0d granted)",
			n_loads, n_reqs, n_grants);
		$display("across all four fit policies, block counts 0, 1, 2, 16 and 31, %s",
			"with and without sender gaps.");
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== fit_policy_block_allocator_unit.f =====
hw/rtl/fpba_pkg.sv
hw/rtl/fpba_cell.sv
hw/rtl/fit_policy_block_allocator_unit.sv
verif/tb_top.sv
